// ===== src/tpf_pkg.sv =====
`timescale 1ns / 1ps

package tpf_pkg;

    localparam int OPCODE_W   = 2;
    localparam int ADDR_W     = 19;
    localparam int DATA_W     = 19;
    localparam int COORD_W    = 10;
    localparam int SCROLL_W   = 16;
    localparam int COLOR_W    = 8;
    localparam int LOG2_W     = 3;
    localparam int CFG_IDX_W  = 1;

    localparam int PIX_W      = 8;
    localparam int PLANE_W    = 9;
    localparam int CELL_W     = 3;
    localparam int MAP_IDX_W  = 12;
    localparam int ROW_PIXELS = 8;
    localparam int ROW_BITS   = ROW_PIXELS * PIX_W;
    localparam int TILE_BYTES = 64;

    localparam int ENTRY_W    = 19;
    localparam int TILE_NUM_W = 13;
    localparam int HFLIP_BIT  = 13;
    localparam int VFLIP_BIT  = 14;
    localparam int PAL_LSB    = 15;
    localparam int PAL_W      = 4;

    localparam logic [LOG2_W-1:0] MAX_LOG2  = 3'd6;
    localparam logic [LOG2_W-1:0] RST_WIDTH  = 3'd6;
    localparam logic [LOG2_W-1:0] RST_HEIGHT = 3'd5;
    localparam logic [CELL_W-1:0] LAST_IN_TILE = 3'd7;

    localparam logic [OPCODE_W-1:0] OP_WR_TILE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_MAP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FETCH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 1'b1;

endpackage

// ===== src/tilemap_plane_pixel_fetch.sv =====
`timescale 1ns / 1ps

// Map read to map_q_reg, then tile-row read to pix_row_reg, one memory port each.
// Throughput: one item per cycle unless out_ready stalls or a sweep runs.
// Reset: size registers return to 6 and 5; the tile store is swept, TILE_COUNT*8
// rows (65536 by default), and the map, MAP_ENTRIES entries, with input held off.
// A write to either size register sweeps the map again.
module tilemap_plane_pixel_fetch #(
    parameter int TILE_COUNT  = 8192,
    parameter int MAP_ENTRIES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpf_pkg::LOG2_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tpf_pkg::OPCODE_W-1:0]        opcode,
    input  logic [tpf_pkg::ADDR_W-1:0]          address,
    input  logic [tpf_pkg::DATA_W-1:0]          write_data,
    input  logic [tpf_pkg::COORD_W-1:0]         screen_x,
    input  logic [tpf_pkg::COORD_W-1:0]         screen_y,
    input  logic signed [tpf_pkg::SCROLL_W-1:0] hscroll,
    input  logic signed [tpf_pkg::SCROLL_W-1:0] vscroll,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tpf_pkg::COLOR_W-1:0]         color_index
);
    import tpf_pkg::*;

    localparam int TILE_W    = $clog2(TILE_COUNT);
    localparam int TILE_ROWS = TILE_COUNT * ROW_PIXELS;
    localparam int ROW_W     = $clog2(TILE_ROWS);
    localparam int MAP_W     = $clog2(MAP_ENTRIES);
    localparam int TILE_SIZE = TILE_COUNT * TILE_BYTES;

    logic [ROW_BITS-1:0] tile_mem [TILE_ROWS];
    logic [ENTRY_W-1:0]  map_mem  [MAP_ENTRIES];

    logic [LOG2_W-1:0] width_log2_reg, width_log2_next;
    logic [LOG2_W-1:0] height_log2_reg, height_log2_next;
    logic              clr_tile_reg, clr_tile_next;
    logic [ROW_W-1:0]  clr_tile_addr_reg, clr_tile_addr_next;
    logic              clr_map_reg, clr_map_next;
    logic [MAP_W-1:0]  clr_map_addr_reg, clr_map_addr_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s2_valid_reg, s2_valid_next;

    logic [CELL_W-1:0]   s1_fx_reg, s1_fy_reg;
    logic                s1_oob_reg;
    logic [ENTRY_W-1:0]  map_q_reg;
    logic [CELL_W-1:0]   s2_fx_reg;
    logic [PAL_W-1:0]    s2_pal_reg;
    logic                s2_zero_reg;
    logic [ROW_BITS-1:0] pix_row_reg;

    logic               en1, en2, accept;
    logic               is_wr_tile, is_wr_map, is_fetch;
    logic               tile_wr, map_wr, fetch_acc, s1_adv;
    logic [LOG2_W-1:0]  wl, hl;
    logic [PLANE_W-1:0] wmask, hmask, px, py;
    logic [MAP_IDX_W-1:0] map_idx;
    logic               map_oob;
    logic [ENTRY_W-1:0] entry;
    logic [TILE_NUM_W-1:0] tile_num;
    logic               tile_oob;
    logic [CELL_W-1:0]  fx1, fy1;
    logic [ROW_W-1:0]   tile_row;
    logic [PIX_W-1:0]   pix;

    // Opcode decode
    always_comb
    begin
        is_wr_tile = 1'b0;
        is_wr_map  = 1'b0;
        is_fetch   = 1'b0;
        unique case (opcode)
            OP_WR_TILE: is_wr_tile = 1'b1;
            OP_WR_MAP:  is_wr_map  = 1'b1;
            OP_FETCH:   is_fetch   = 1'b1;
            default:    ;
        endcase
    end

    assign en2       = !s2_valid_reg || out_ready;
    assign en1       = !s1_valid_reg || en2;
    assign in_ready  = en1 && !clr_tile_reg && !clr_map_reg;
    assign accept    = in_valid && in_ready;
    assign fetch_acc = accept && is_fetch;
    assign tile_wr   = accept && is_wr_tile && ({1'b0, address} < (ADDR_W+1)'(TILE_SIZE));
    assign map_wr    = accept && is_wr_map && ({1'b0, address} < (ADDR_W+1)'(MAP_ENTRIES));
    assign s1_adv    = en2 && s1_valid_reg;

    // Plane coordinates and map index
    always_comb
    begin
        wl      = (width_log2_reg > MAX_LOG2) ? MAX_LOG2 : width_log2_reg;
        hl      = (height_log2_reg > MAX_LOG2) ? MAX_LOG2 : height_log2_reg;
        wmask   = PLANE_W'(({1'b0, PLANE_W'(ROW_PIXELS)} << wl) - 1'b1);
        hmask   = PLANE_W'(({1'b0, PLANE_W'(ROW_PIXELS)} << hl) - 1'b1);
        px      = PLANE_W'(screen_x[PLANE_W-1:0] - hscroll[PLANE_W-1:0]) & wmask;
        py      = PLANE_W'(screen_y[PLANE_W-1:0] + vscroll[PLANE_W-1:0]) & hmask;
        map_idx = MAP_IDX_W'((MAP_IDX_W'(py[PLANE_W-1:CELL_W]) << wl)
                  + MAP_IDX_W'(px[PLANE_W-1:CELL_W]));
        map_oob = {1'b0, map_idx} >= (MAP_IDX_W+1)'(MAP_ENTRIES);
    end

    // Entry decode and tile row select
    always_comb
    begin
        entry    = s1_oob_reg ? '0 : map_q_reg;
        tile_num = entry[TILE_NUM_W-1:0];
        tile_oob = {1'b0, tile_num} >= (TILE_NUM_W+1)'(TILE_COUNT);
        fx1      = entry[HFLIP_BIT] ? (LAST_IN_TILE - s1_fx_reg) : s1_fx_reg;
        fy1      = entry[VFLIP_BIT] ? (LAST_IN_TILE - s1_fy_reg) : s1_fy_reg;
        tile_row = tile_oob ? '0 : {tile_num[TILE_W-1:0], fy1};
    end

    assign pix         = pix_row_reg[{s2_fx_reg, 3'b000} +: PIX_W];
    assign out_valid   = s2_valid_reg;
    assign color_index = (s2_zero_reg || pix == '0) ? '0 : ({s2_pal_reg, 4'b0000} | pix);

    // Control next state
    always_comb
    begin
        width_log2_next    = width_log2_reg;
        height_log2_next   = height_log2_reg;
        clr_tile_next      = clr_tile_reg;
        clr_tile_addr_next = clr_tile_addr_reg;
        clr_map_next       = clr_map_reg;
        clr_map_addr_next  = clr_map_addr_reg;

        if (clr_tile_reg)
        begin
            clr_tile_addr_next = ROW_W'(clr_tile_addr_reg + 1'b1);
            if (clr_tile_addr_reg == ROW_W'(TILE_ROWS - 1))
            begin
                clr_tile_next = 1'b0;
            end
        end

        if (clr_map_reg)
        begin
            clr_map_addr_next = MAP_W'(clr_map_addr_reg + 1'b1);
            if (clr_map_addr_reg == MAP_W'(MAP_ENTRIES - 1))
            begin
                clr_map_next = 1'b0;
            end
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH_LOG2:  width_log2_next  = cfg_data;
                CFG_HEIGHT_LOG2: height_log2_next = cfg_data;
                default:         ;
            endcase
            // restart the map sweep
            clr_map_next      = 1'b1;
            clr_map_addr_next = '0;
        end

        s1_valid_next = en1 ? fetch_acc : s1_valid_reg;
        s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg    <= RST_WIDTH;
            height_log2_reg   <= RST_HEIGHT;
            clr_tile_reg      <= 1'b1;
            clr_tile_addr_reg <= '0;
            clr_map_reg       <= 1'b1;
            clr_map_addr_reg  <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
        end
        else
        begin
            width_log2_reg    <= width_log2_next;
            height_log2_reg   <= height_log2_next;
            clr_tile_reg      <= clr_tile_next;
            clr_tile_addr_reg <= clr_tile_addr_next;
            clr_map_reg       <= clr_map_next;
            clr_map_addr_reg  <= clr_map_addr_next;
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (fetch_acc)
        begin
            s1_fx_reg  <= px[CELL_W-1:0];
            s1_fy_reg  <= py[CELL_W-1:0];
            s1_oob_reg <= map_oob;
        end
        if (s1_adv)
        begin
            s2_fx_reg   <= fx1;
            s2_pal_reg  <= entry[PAL_LSB +: PAL_W];
            s2_zero_reg <= tile_oob;
        end
    end

    // Map memory: read before write at the same edge
    always_ff @(posedge clk)
    begin
        if (fetch_acc)
        begin
            map_q_reg <= map_mem[map_idx[MAP_W-1:0]];
        end
        if (clr_map_reg)
        begin
            map_mem[clr_map_addr_reg] <= '0;
        end
        else if (map_wr)
        begin
            map_mem[address[MAP_W-1:0]] <= write_data;
        end
    end

    // Tile memory, one row of eight pixels per entry, byte writes
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pix_row_reg <= tile_mem[tile_row];
        end
        if (clr_tile_reg)
        begin
            tile_mem[clr_tile_addr_reg] <= '0;
        end
        else if (tile_wr)
        begin
            tile_mem[address[ROW_W+CELL_W-1:CELL_W]][{address[CELL_W-1:0], 3'b000} +: PIX_W]
                <= write_data[PIX_W-1:0];
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

package pixel_check_pkg;

    import tpf_pkg::*;

    localparam int TILE_TOTAL   = 8192;
    localparam int MAP_TOTAL    = 4096;
    localparam int REPORT_LIMIT = 10;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
        logic [COORD_W-1:0]  screen_x;
        logic [COORD_W-1:0]  screen_y;
        logic [SCROLL_W-1:0] hscroll;
        logic [SCROLL_W-1:0] vscroll;
    } plane_item_t;

    class pixel_checker;
        bit [PIX_W-1:0]   tile_pixels [TILE_TOTAL*TILE_BYTES];
        bit [ENTRY_W-1:0] tile_map [MAP_TOTAL];
        bit [LOG2_W-1:0]  width_log2  = RST_WIDTH;
        bit [LOG2_W-1:0]  height_log2 = RST_HEIGHT;
        bit [COLOR_W-1:0] expected_colors [$];
        int               mismatches = 0;

        function bit [LOG2_W-1:0] clamp(bit [LOG2_W-1:0] value);
            return (value > MAX_LOG2) ? MAX_LOG2 : value;
        endfunction

        // a resize clears the whole map
        function void write_size(logic [CFG_IDX_W-1:0] index, logic [LOG2_W-1:0] value);
            if (index == CFG_WIDTH_LOG2)
                width_log2 = value;
            else
                height_log2 = value;
            foreach (tile_map[i])
                tile_map[i] = '0;
        endfunction

        function bit [COLOR_W-1:0] predict_color(plane_item_t item);
            bit [LOG2_W-1:0]   wl;
            bit [LOG2_W-1:0]   hl;
            bit [SCROLL_W-1:0] px;
            bit [SCROLL_W-1:0] py;
            int unsigned       map_slot;
            bit [ENTRY_W-1:0]  entry;
            bit [CELL_W-1:0]   fx;
            bit [CELL_W-1:0]   fy;
            bit [PIX_W-1:0]    pixel;
            wl = clamp(width_log2);
            hl = clamp(height_log2);
            px = (SCROLL_W'(item.screen_x) - item.hscroll) & ((SCROLL_W'(8) << wl) - 1'b1);
            py = (SCROLL_W'(item.screen_y) + item.vscroll) & ((SCROLL_W'(8) << hl) - 1'b1);
            map_slot = ((int'(py) >> CELL_W) << wl) + (int'(px) >> CELL_W);
            entry = (map_slot < MAP_TOTAL) ? tile_map[map_slot] : '0;
            fx = px[CELL_W-1:0];
            fy = py[CELL_W-1:0];
            if (entry[HFLIP_BIT])
                fx = LAST_IN_TILE - fx;
            if (entry[VFLIP_BIT])
                fy = LAST_IN_TILE - fy;
            pixel = tile_pixels[int'(entry[TILE_NUM_W-1:0]) * TILE_BYTES
                                + int'(fy) * ROW_PIXELS + int'(fx)];
            if (pixel == '0)
                return '0;
            return {entry[PAL_LSB +: PAL_W], 4'b0000} | pixel;
        endfunction

        function void accept_item(plane_item_t item);
            case (item.opcode)
                OP_WR_TILE:
                    tile_pixels[item.address] = item.write_data[PIX_W-1:0];
                OP_WR_MAP:
                    if (item.address < MAP_TOTAL)
                        tile_map[item.address] = item.write_data;
                OP_FETCH:
                    expected_colors.push_back(predict_color(item));
                default:
                    ;
            endcase
        endfunction

        function void note_failure(string message);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", message);
        endfunction

        function void check_color(logic [COLOR_W-1:0] actual);
            bit [COLOR_W-1:0] wanted;
            if (expected_colors.size() == 0)
            begin
                note_failure($sformatf("color_index %02h with no fetch waiting", actual));
                return;
            end
            wanted = expected_colors.pop_front();
            if (actual !== wanted)
                note_failure($sformatf("color_index mismatch: expected %02h, got %02h",
                                       wanted, actual));
        endfunction

        function int outstanding();
            return expected_colors.size();
        endfunction
    endclass

endpackage

module testbench;

    import tpf_pkg::*;
    import pixel_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 75;
    localparam int WARMUP_ITEMS   = 50;
    localparam int PHASES         = 9;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LOG2_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [ADDR_W-1:0]     address;
    logic [DATA_W-1:0]     write_data;
    logic [COORD_W-1:0]    screen_x;
    logic [COORD_W-1:0]    screen_y;
    logic signed [SCROLL_W-1:0] hscroll;
    logic signed [SCROLL_W-1:0] vscroll;
    logic                  out_valid;
    logic                  out_ready;
    logic [COLOR_W-1:0]    color_index;

    pixel_checker color_board = new();

    int idle_cycles   = 0;
    bit hold_request  = 1'b0;

    logic [CFG_IDX_W-1:0] phase_reg [PHASES] = '{
        CFG_WIDTH_LOG2, CFG_HEIGHT_LOG2, CFG_WIDTH_LOG2, CFG_HEIGHT_LOG2, CFG_WIDTH_LOG2,
        CFG_HEIGHT_LOG2, CFG_WIDTH_LOG2, CFG_HEIGHT_LOG2, CFG_HEIGHT_LOG2
    };
    logic [LOG2_W-1:0] phase_value [PHASES] = '{
        3'd0, 3'd0, 3'd7, 3'd7, 3'd2, 3'd3, 3'd6, 3'd6, 3'd1
    };
    logic [LOG2_W-1:0] plane_log2 [2] = '{RST_WIDTH, RST_HEIGHT};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    tilemap_plane_pixel_fetch #(
        .TILE_COUNT  (TILE_TOTAL),
        .MAP_ENTRIES (MAP_TOTAL)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .address     (address),
        .write_data  (write_data),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .hscroll     (hscroll),
        .vscroll     (vscroll),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .color_index (color_index)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            color_board.accept_item(plane_item_t'{opcode, address, write_data,
                                                  screen_x, screen_y, hscroll, vscroll});
        if (rst_n && out_valid && out_ready)
            color_board.check_color(color_index);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_tile();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(0, TILE_TOTAL - 1);
    endfunction

    function automatic plane_item_t directed_item(logic [OPCODE_W-1:0] op,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] data,
                                                  logic [COORD_W-1:0] sx,
                                                  logic [COORD_W-1:0] sy,
                                                  logic [SCROLL_W-1:0] hs,
                                                  logic [SCROLL_W-1:0] vs);
        return plane_item_t'{op, addr, data, sx, sy, hs, vs};
    endfunction

    function automatic plane_item_t random_item(int cells_log2);
        plane_item_t item;
        int          roll;
        item.address    = ADDR_W'($urandom);
        item.write_data = DATA_W'($urandom);
        item.screen_x   = COORD_W'($urandom);
        item.screen_y   = COORD_W'($urandom);
        item.hscroll    = SCROLL_W'($urandom);
        item.vscroll    = SCROLL_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            item.opcode = OP_WR_TILE;
            if ($urandom_range(0, 19) != 0)
                item.address = ADDR_W'(pick_tile() * TILE_BYTES
                                       + $urandom_range(0, TILE_BYTES - 1));
        end
        else if (roll < 45)
        begin
            item.opcode = OP_WR_MAP;
            if ($urandom_range(0, 9) != 0)
            begin
                item.address    = ADDR_W'($urandom_range(0, (1 << cells_log2) - 1));
                item.write_data = {PAL_W'($urandom), 2'($urandom), TILE_NUM_W'(pick_tile())};
            end
        end
        else if (roll < 95)
            item.opcode = OP_FETCH;
        else
            item.opcode = OP_UNUSED;
        return item;
    endfunction

    task automatic send_item(plane_item_t item);
        int gap;
        in_valid   <= 1'b1;
        opcode     <= item.opcode;
        address    <= item.address;
        write_data <= item.write_data;
        screen_x   <= item.screen_x;
        screen_y   <= item.screen_y;
        hscroll    <= item.hscroll;
        vscroll    <= item.vscroll;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (color_board.outstanding() != 0);
    endtask

    task automatic set_plane_size(logic [CFG_IDX_W-1:0] index, logic [LOG2_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        color_board.write_size(index, value);
        plane_log2[index] = value;
        cfg_write <= 1'b0;
    endtask

    function automatic int plane_cells_log2();
        return int'(color_board.clamp(plane_log2[CFG_WIDTH_LOG2]))
               + int'(color_board.clamp(plane_log2[CFG_HEIGHT_LOG2]));
    endfunction

    // receiver: random back-pressure, one long hold when asked
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_WIDTH_LOG2;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_WR_TILE;
        address    <= '0;
        write_data <= '0;
        screen_x   <= '0;
        screen_y   <= '0;
        hscroll    <= '0;
        vscroll    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty stores, tile corners, flips, palettes, range edges
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_TILE, 19'd0,      19'h7ffff,   10'd1023, 10'd1023,
                                16'hffff, 16'hffff));
        send_item(directed_item(OP_WR_TILE, 19'd7,      19'h00001,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_TILE, 19'd56,     19'h00080,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_TILE, 19'd63,     19'h0005a,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_TILE, 19'h7ffff,  19'h00033,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_TILE, 19'h7ffc0,  19'h000c4,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd0,      {4'hf, 2'b00, 13'd0},    10'd0, 10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd1,      {4'h3, 2'b01, 13'd0},    10'd0, 10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd64,     {4'h0, 2'b10, 13'd0},    10'd0, 10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd65,     {4'h9, 2'b11, 13'd0},    10'd0, 10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd2047,   {4'hf, 2'b11, 13'h1fff}, 10'd0, 10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'd4096,   19'h7ffff,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_WR_MAP,  19'h7ffff,  19'h7ffff,   10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_UNUSED,  19'h7ffff,  19'h7ffff,   10'd1023, 10'd1023,
                                16'hffff, 16'hffff));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd0,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd7,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd8,    10'd0,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd0,    10'd8,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd15,   10'd15,
                                16'h0000, 16'h0000));
        send_item(directed_item(OP_FETCH,   19'h7ffff,  19'h7ffff,   10'd1023, 10'd1023,
                                16'h8000, 16'h7fff));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd0,    10'd0,
                                16'h7fff, 16'h8000));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd0,    10'd0,
                                16'h0001, 16'hffff));
        send_item(directed_item(OP_FETCH,   19'd0,      19'd0,       10'd1023, 10'd1023,
                                16'h0000, 16'h0000));

        for (int i = 0; i < WARMUP_ITEMS; i++)
            send_item(random_item(plane_cells_log2()));

        for (int p = 0; p < PHASES; p++)
        begin
            set_plane_size(phase_reg[p], phase_value[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 10)
                    hold_request = 1'b1;
                if (i == PHASE_ITEMS / 2)
                    drain_results();
                send_item(random_item(plane_cells_log2()));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (color_board.mismatches == 0 && color_board.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tpf_pkg.sv
src/tilemap_plane_pixel_fetch.sv
sim/testbench.sv
